// File: sv/group_membership_scope_table_macros.svh
// assertion macros for the group membership scope table
`ifndef GROUP_MEMBERSHIP_SCOPE_TABLE_MACROS_SVH
`define GROUP_MEMBERSHIP_SCOPE_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define GMST_ASSERT_IMPL(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define GMST_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("forbidden condition");
`else
`define GMST_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define GMST_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/gmst_pkg.sv
// ----------------------------------------------------------------------------
// gmst_pkg
// shared types and constants of the group membership scope table
// ----------------------------------------------------------------------------
`default_nettype none
package gmst_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);

	localparam logic [2:0] ACT_APPLY = 3'd0;
	localparam logic [2:0] ACT_GROUP = 3'd1;
	localparam logic [2:0] ACT_REP = 3'd2;
	localparam logic [2:0] ACT_EXPORT = 3'd3;
	localparam logic [2:0] ACT_USABLE = 3'd4;

	localparam logic [2:0] OBJ_MEMBER = 3'd0;
	localparam logic [2:0] OBJ_GPREFIX = 3'd1;
	localparam logic [2:0] OBJ_NPREFIX = 3'd2;
	localparam logic [2:0] OBJ_LINK = 3'd3;

	localparam logic [1:0] OST_ACTIVE = 2'd0;
	localparam logic [1:0] OST_WITHDRAWN = 2'd1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVAL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOENT = 2'd3;

	localparam logic CFG_LOCAL_NODE = 1'b0;
	localparam logic CFG_TABLE_LIMIT = 1'b1;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] object_type;
		logic [1:0] object_state;
		logic identity_ok;
		logic [31:0] originator;
		logic [31:0] remote_node;
		logic [31:0] member_group;
		logic [31:0] prefix_group;
		logic [31:0] peer_node;
		logic [31:0] query_node;
		logic [31:0] query_group;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic decision;
		logic [31:0] found_group;
		logic [31:0] found_node;
	} rsp_t;

	// one entry of the membership memory
	typedef struct packed {
		logic active;
		logic [31:0] group;
		logic [31:0] node;
	} entry_t;
endpackage
`default_nettype wire

// File: sv/gmst_ram.sv
// ----------------------------------------------------------------------------
// gmst_ram
// single port entry memory, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module gmst_ram
	import gmst_pkg::*;
(
	input wire logic clk,
	input wire logic we,
	input wire logic [IdxW-1:0] addr,
	input wire entry_t wdata,
	output entry_t rdata
);
	entry_t mem [TableDepth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: sv/gmst_ctrl.sv
// ----------------------------------------------------------------------------
// gmst_ctrl
// sequencer: scans the entry memory once per lookup and updates it
// ----------------------------------------------------------------------------
`default_nettype none
module gmst_ctrl
	import gmst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [31:0] self_node_id,
	input wire logic [6:0] table_limit,
	input wire logic in_valid,
	output logic in_stall,
	input wire req_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output rsp_t out_data,
	output logic ram_we,
	output logic [IdxW-1:0] ram_addr,
	output entry_t ram_wdata,
	input wire entry_t ram_rdata
);
	typedef enum logic [2:0] {S_IDLE, S_SETUP, S_SCAN, S_DONE, S_OUT} state_t;
	// lookup kinds, one full scan each
	typedef enum logic [1:0] {L_NODE, L_REP} kind_t;

	state_t state_q;
	req_t req_q;
	kind_t kind_q;
	logic [31:0] key_q;
	logic [2:0] step_q;
	logic [CntW-1:0] used_q;
	logic [CntW-1:0] cnt_q;
	logic rd_vld_q;
	logic [IdxW-1:0] rd_idx_q;
	// scan results
	logic hit_q, hit_act_q, free_q;
	logic [IdxW-1:0] hit_idx_q, free_idx_q;
	logic [31:0] hit_grp_q, best_q;
	// stored lookup results
	logic [31:0] og_q, rg_q;
	rsp_t rsp_q;

	logic [CntW-1:0] limit;
	assign limit = (table_limit == 7'd0) ? CntW'(0) :
		((CntW'(table_limit) < CntW'(TableDepth)) && (7'(TableDepth) > table_limit))
		? CntW'(table_limit) : CntW'(TableDepth);

	logic [IdxW-1:0] wr_idx;
	assign wr_idx = hit_q ? hit_idx_q : free_q ? free_idx_q : used_q[IdxW-1:0];

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = rsp_q;
	// scan address while scanning, target slot at write back
	assign ram_addr = (state_q == S_SCAN) ? cnt_q[IdxW-1:0] :
		(state_q == S_DONE) ? wr_idx : rd_idx_q;

	// write back of an apply
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = '0;
		if (state_q == S_DONE && req_q.action == ACT_APPLY) begin
			ram_wdata.node = req_q.originator;
			ram_wdata.group = req_q.member_group;
			ram_wdata.active = 1'b1;
			if (req_q.object_state == OST_WITHDRAWN) begin
				ram_we = hit_q;
				ram_wdata.node = req_q.originator;
				ram_wdata.group = hit_grp_q;
				ram_wdata.active = 1'b0;
			end else begin
				ram_we = hit_q || free_q || (used_q < limit);
			end
		end
	end

	// decide next lookup or final result from gathered groups
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			cnt_q <= '0;
			rd_vld_q <= 1'b0;
			step_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						step_q <= '0;
						rsp_q <= '0;
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					// choose the scan for this step, or finish
					state_q <= S_SCAN;
					cnt_q <= '0;
					rd_vld_q <= 1'b0;
					hit_q <= 1'b0;
					hit_act_q <= 1'b0;
					free_q <= 1'b0;
					best_q <= '0;
					kind_q <= L_NODE;
					unique case (req_q.action)
						ACT_APPLY: begin
							key_q <= req_q.originator;
							if (req_q.object_type != OBJ_MEMBER) begin
								state_q <= S_OUT;
							end else if (!req_q.identity_ok || req_q.originator == '0) begin
								rsp_q.status <= ST_INVAL;
								state_q <= S_OUT;
							end else if (req_q.object_state != OST_WITHDRAWN &&
								(req_q.object_state != OST_ACTIVE ||
								req_q.member_group == '0)) begin
								rsp_q.status <= ST_INVAL;
								state_q <= S_OUT;
							end
						end
						ACT_GROUP: begin
							key_q <= req_q.query_node;
							if (req_q.query_node == '0) begin
								rsp_q.status <= ST_INVAL;
								state_q <= S_OUT;
							end
						end
						ACT_REP: begin
							key_q <= req_q.query_group;
							kind_q <= L_REP;
							if (req_q.query_group == '0) begin
								rsp_q.status <= ST_INVAL;
								state_q <= S_OUT;
							end
						end
						ACT_EXPORT, ACT_USABLE: begin
							if ((req_q.action == ACT_EXPORT &&
								req_q.object_state == OST_WITHDRAWN) ||
								(req_q.action == ACT_USABLE && req_q.object_state == OST_ACTIVE &&
								req_q.object_type == OBJ_MEMBER) ||
								(req_q.action == ACT_EXPORT && req_q.object_type == OBJ_MEMBER)) begin
								rsp_q.decision <= 1'b1;
								state_q <= S_OUT;
							end else if ((req_q.action == ACT_USABLE &&
								req_q.object_state != OST_ACTIVE) ||
								(req_q.object_type != OBJ_GPREFIX &&
								req_q.object_type != OBJ_NPREFIX &&
								req_q.object_type != OBJ_LINK)) begin
								state_q <= S_OUT;
							end else if (req_q.object_type == OBJ_GPREFIX) begin
								key_q <= req_q.prefix_group;
								kind_q <= L_REP;
								if (req_q.prefix_group == '0) state_q <= S_OUT;
							end else begin
								// step 0 originator, 1 remote or viewer, 2 viewer
								if (step_q == 3'd0) begin
									key_q <= req_q.originator;
									if (req_q.originator == '0) state_q <= S_OUT;
								end else if (step_q == 3'd1 && req_q.object_type == OBJ_LINK) begin
									key_q <= req_q.remote_node;
									if (req_q.remote_node == '0) state_q <= S_OUT;
								end else begin
									key_q <= (req_q.action == ACT_EXPORT) ?
										req_q.peer_node : self_node_id;
									if ((req_q.action == ACT_EXPORT ? req_q.peer_node :
										self_node_id) == '0) state_q <= S_OUT;
								end
							end
						end
						default: begin
							rsp_q.status <= ST_INVAL;
							state_q <= S_OUT;
						end
					endcase
				end
				S_SCAN: begin
					// one address per cycle, compare in the next cycle
					if (cnt_q < used_q) begin
						cnt_q <= cnt_q + CntW'(1);
						rd_idx_q <= cnt_q[IdxW-1:0];
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						if (!rd_vld_q) state_q <= S_DONE;
					end
					if (rd_vld_q) begin
						if (kind_q == L_NODE) begin
							if (!hit_q && ram_rdata.node == key_q) begin
								hit_q <= 1'b1;
								hit_idx_q <= rd_idx_q;
								hit_act_q <= ram_rdata.active;
								hit_grp_q <= ram_rdata.group;
							end
							if (!free_q && !ram_rdata.active) begin
								free_q <= 1'b1;
								free_idx_q <= rd_idx_q;
							end
						end else if (ram_rdata.active && ram_rdata.group == key_q &&
							(best_q == '0 || ram_rdata.node < best_q)) begin
							best_q <= ram_rdata.node;
						end
					end
				end
				S_DONE: begin
					state_q <= S_OUT;
					rd_idx_q <= wr_idx;
					unique case (req_q.action)
						ACT_APPLY: begin
							if (req_q.object_state != OST_WITHDRAWN && !hit_q && !free_q) begin
								if (used_q < limit) used_q <= used_q + CntW'(1);
								else rsp_q.status <= ST_FULL;
							end
						end
						ACT_GROUP: begin
							if (hit_q && hit_act_q) rsp_q.found_group <= hit_grp_q;
							else rsp_q.status <= ST_NOENT;
						end
						ACT_REP: begin
							if (best_q != '0) rsp_q.found_node <= best_q;
							else rsp_q.status <= ST_NOENT;
						end
						default: begin
							if (req_q.object_type == OBJ_GPREFIX) begin
								rsp_q.decision <= (best_q != '0) && (best_q == req_q.originator);
							end else if (!(hit_q && hit_act_q)) begin
								rsp_q.decision <= 1'b0;
							end else if (step_q == 3'd0) begin
								og_q <= hit_grp_q;
								step_q <= 3'd1;
								state_q <= S_SETUP;
							end else if (step_q == 3'd1 && req_q.object_type == OBJ_LINK) begin
								rg_q <= hit_grp_q;
								if (og_q != hit_grp_q) begin
									rsp_q.decision <= 1'b1;
								end else begin
									step_q <= 3'd2;
									state_q <= S_SETUP;
								end
							end else begin
								rsp_q.decision <= (hit_grp_q == og_q);
							end
						end
					endcase
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/group_membership_scope_table.sv
// group membership scope table, top level
// a request runs setup then result; one that needs a lookup runs a memory scan and a done step between
// a link check takes up to three scans
// one item at a time: the next one is accepted once the result beat has been taken
// reset clears the fill count and control; entries are undefined until written
// ----------------------------------------------------------------------------
// group_membership_scope_table
// node to group membership table with export and usable checks
// ----------------------------------------------------------------------------
`default_nettype none
`include "group_membership_scope_table_macros.svh"
module group_membership_scope_table
	import gmst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire req_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output rsp_t out_data
);
	logic [31:0] local_node_q;
	logic [6:0] table_limit_q;
	logic ram_we;
	logic [IdxW-1:0] ram_addr;
	entry_t ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_node_q <= 32'd1;
			table_limit_q <= 7'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOCAL_NODE: local_node_q <= cfg_data;
				CFG_TABLE_LIMIT: table_limit_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	gmst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .self_node_id(local_node_q),
		.table_limit(table_limit_q), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .ram_we(ram_we), .ram_addr(ram_addr),
		.ram_wdata(ram_wdata), .ram_rdata(ram_rdata)
	);

	gmst_ram u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	`GMST_ASSERT_NEVER(a_no_write_while_out, clk, arst_n, ram_we && out_valid)
	`GMST_ASSERT_IMPL(a_accept_busy, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	`GMST_ASSERT_NEVER(a_status_dec, clk, arst_n, out_valid && out_data.decision &&
		out_data.status != ST_OK)
endmodule
`default_nettype wire
